@@ design/sha256_stream_hasher_top_assert.svh @@
// assertion macros for the sha-256 stream hasher
// expects i_clk and i_rst_n in the scope of use
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/shs_pkg.sv @@
// shared types, constants and round functions of the sha-256 stream hasher
// no dependencies
`timescale 1ns / 1ps

package shs_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_vars;
    typedef logic [15:0][31:0] t_sched;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // controls from the sequencer to the compression datapath
    typedef struct packed {
        logic       load_w;
        logic       load_v;
        logic       round;
        logic [5:0] rnd_idx;
    } t_cmp_ctrl;

    localparam t_word K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ design/shs_in_if.sv @@
// input channel of the sha-256 stream hasher: operation and message byte
// depends on nothing
`timescale 1ns / 1ps

interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

@@ design/shs_out_if.sv @@
// output channel of the sha-256 stream hasher: one digest word per transaction
// depends on nothing
`timescale 1ns / 1ps

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

@@ design/sha256_stream_hasher_top.sv @@
// sha-256 stream hasher top level: sequencer, block and chaining memories
// depends on shs_pkg, shs_in_if, shs_out_if, shs_compress and the assertion header
//
//  channel | dir | payload                               | transaction
//  --------+-----+---------------------------------------+-------------------------
//  i_msg   | in  | operation, data_byte                  | valid & ready at clk edge
//  o_dig   | out | digest_word, word_index, last_word    | valid & ready at clk edge
//
// an absorb is taken while idle; the byte that completes a block starts a compression
// that holds i_msg.ready low through the load, the 64 rounds and the fold-back
// a finish runs one or two such compressions (two when 56 or more bytes pending),
// then sends eight words, each through a read and a write state, waiting while o_dig.ready is low
// the round loop of one round per clock sets the rate
// i_rst_n is synchronous; chaining words read as the initial hash until rewritten
`timescale 1ns / 1ps
`include "sha256_stream_hasher_top_assert.svh"

module sha256_stream_hasher_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    shs_in_if.sink    i_msg,
    shs_out_if.source o_dig
);
    import shs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FIN,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    // what the load phase feeds into the schedule window
    typedef enum logic [1:0] {
        KIND_DATA,   // a full block of message bytes
        KIND_PAD,    // pending bytes, the 0x80 marker, zeros, maybe the length
        KIND_TAIL    // zeros and the length only
    } t_kind;

    t_state r_state;
    t_kind  r_kind;
    logic [5:0]  r_cnt;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [2:0]  r_idx;
    logic        r_pad_len;
    logic        r_out_valid;

    // payload registers
    logic [23:0] r_acc;
    t_word       r_pad_word;
    logic [3:0]  r_pad_idx;
    t_word       r_out_word;
    logic [2:0]  r_out_index;
    logic        r_out_last;

    // block buffer: sixteen big-endian words
    t_word r_blk_mem [16];
    t_word r_blk_rd;

    // chaining words with a valid bit per entry
    t_word      r_chn_mem [8];
    logic [7:0] r_chn_vld;
    t_word      r_chn_rd;
    logic       r_chn_rd_vld;
    logic [2:0] r_chn_raddr;

    logic       in_acc;
    logic       absorb_acc;
    logic       finish_acc;
    logic       out_free;
    logic       blk_rd_en;
    logic       chn_rd_en;
    logic [2:0] chn_raddr;
    logic       chn_wr_en;
    logic [2:0] chn_waddr;
    t_word      chn_wdata;
    t_word      chn_eff;
    logic       chn_clear;
    logic [3:0] ld_idx;
    t_word      ld_word;
    t_word      pad_word;
    t_cmp_ctrl  cmp_ctrl;
    t_vars      cmp_vars;

    // handshakes
    assign i_msg.ready = i_rst_n && (r_state == ST_IDLE);
    assign in_acc      = i_msg.valid && i_msg.ready;
    assign absorb_acc  = in_acc && (i_msg.operation == OP_ABSORB);
    assign finish_acc  = in_acc && (i_msg.operation == OP_FINISH);
    assign out_free    = !r_out_valid || o_dig.ready;

    assign o_dig.valid       = r_out_valid;
    assign o_dig.digest_word = r_out_word;
    assign o_dig.word_index  = r_out_index;
    assign o_dig.last_word   = r_out_last;

    // last partial word with the marker byte appended behind the pending bytes
    always_comb begin
        unique case (r_fill[1:0])
            2'd0: pad_word = {PAD_BYTE, 24'd0};
            2'd1: pad_word = {r_acc[7:0], PAD_BYTE, 16'd0};
            2'd2: pad_word = {r_acc[15:0], PAD_BYTE, 8'd0};
            2'd3: pad_word = {r_acc[23:0], PAD_BYTE};
            default: pad_word = '0;
        endcase
    end

    // block buffer: a word is written once its fourth byte arrives
    assign blk_rd_en = (r_state == ST_LOAD) && (r_cnt < 6'd16);

    always_ff @(posedge i_clk) begin
        if (absorb_acc && (r_fill[1:0] == 2'b11)) begin
            r_blk_mem[r_fill[5:2]] <= {r_acc, i_msg.data_byte};
        end
        if (blk_rd_en) begin
            r_blk_rd <= r_blk_mem[r_cnt[3:0]];
        end
    end

    // chaining memory: read during load, fold-back and emit, written in fold-back
    assign chn_rd_en = (((r_state == ST_LOAD) || (r_state == ST_FIN)) && (r_cnt < 6'd8))
                       || (r_state == ST_EMIT_RD);
    assign chn_raddr = (r_state == ST_EMIT_RD) ? r_idx : r_cnt[2:0];
    assign chn_eff   = r_chn_rd_vld ? r_chn_rd : INIT_H[r_chn_raddr];
    // write lags the read by one entry, so the two never meet
    assign chn_wr_en = (r_state == ST_FIN) && (r_cnt != 6'd0);
    assign chn_waddr = r_cnt[2:0] - 3'd1;
    assign chn_wdata = chn_eff + cmp_vars[chn_waddr];
    assign chn_clear = (r_state == ST_EMIT_WR) && out_free && (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (chn_rd_en) begin
            r_chn_rd     <= r_chn_mem[chn_raddr];
            r_chn_rd_vld <= r_chn_vld[chn_raddr];
            r_chn_raddr  <= chn_raddr;
        end
        if (chn_wr_en) begin
            r_chn_mem[chn_waddr] <= chn_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chn_vld <= '0;
        end else if (chn_clear) begin
            r_chn_vld <= '0;
        end else if (chn_wr_en) begin
            r_chn_vld[chn_waddr] <= 1'b1;
        end
    end

    // word going into the schedule window, in the cycle after its read
    assign ld_idx = r_cnt[3:0] - 4'd1;

    always_comb begin
        ld_word = '0;
        unique case (r_kind)
            KIND_DATA: ld_word = r_blk_rd;
            KIND_PAD: begin
                if (ld_idx < r_pad_idx) begin
                    ld_word = r_blk_rd;
                end else if (ld_idx == r_pad_idx) begin
                    ld_word = r_pad_word;
                end else if (r_pad_len && (ld_idx == 4'd14)) begin
                    ld_word = r_len[63:32];
                end else if (r_pad_len && (ld_idx == 4'd15)) begin
                    ld_word = r_len[31:0];
                end
            end
            KIND_TAIL: begin
                if (ld_idx == 4'd14) begin
                    ld_word = r_len[63:32];
                end else if (ld_idx == 4'd15) begin
                    ld_word = r_len[31:0];
                end
            end
            default: ld_word = '0;
        endcase
    end

    always_comb begin
        cmp_ctrl.load_w  = (r_state == ST_LOAD) && (r_cnt != 6'd0);
        cmp_ctrl.load_v  = (r_state == ST_LOAD) && (r_cnt != 6'd0) && (r_cnt <= 6'd8);
        cmp_ctrl.round   = (r_state == ST_ROUND);
        cmp_ctrl.rnd_idx = r_cnt;
    end

    shs_compress u_compress (
        .i_clk  (i_clk),
        .i_ctrl (cmp_ctrl),
        .i_word (ld_word),
        .i_var  (chn_eff),
        .o_vars (cmp_vars)
    );

    // payload captures
    always_ff @(posedge i_clk) begin
        if (absorb_acc) begin
            r_acc <= {r_acc[15:0], i_msg.data_byte};
        end
        if (finish_acc) begin
            r_pad_word <= pad_word;
            r_pad_idx  <= r_fill[5:2];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= KIND_DATA;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_pad_len   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new word takes the slot, otherwise a taken word frees it
            if ((r_state == ST_EMIT_WR) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_dig.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (absorb_acc) begin
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_len   <= r_len + 64'd512;
                            r_kind  <= KIND_DATA;
                            r_state <= ST_LOAD;
                        end
                    end else if (finish_acc) begin
                        // length of the whole message, pending bytes included
                        r_len     <= r_len + {55'd0, r_fill, 3'd0};
                        r_fill    <= '0;
                        r_kind    <= KIND_PAD;
                        r_pad_len <= (r_fill[5:3] != 3'b111);
                        r_state   <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (r_cnt == 6'd16) begin
                        r_cnt   <= '0;
                        r_state <= ST_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_ROUND: begin
                    if (r_cnt == 6'd63) begin
                        r_cnt   <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_FIN: begin
                    if (r_cnt == 6'd8) begin
                        r_cnt <= '0;
                        if (r_kind == KIND_DATA) begin
                            r_state <= ST_IDLE;
                        end else if ((r_kind == KIND_PAD) && !r_pad_len) begin
                            // length did not fit, one more block of zeros and length
                            r_kind  <= KIND_TAIL;
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_EMIT_RD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_WR;
                end
                ST_EMIT_WR: begin
                    if (out_free) begin
                        r_out_word  <= chn_eff;
                        r_out_index <= r_idx;
                        r_out_last  <= (r_idx == 3'd7);
                        if (r_idx == 3'd7) begin
                            r_idx   <= '0;
                            r_len   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    `SHS_ASSERT_NOW(a_last_is_seven, o_dig.valid && o_dig.last_word, o_dig.word_index == 3'd7, "last word not at index seven")
    `SHS_ASSERT_NEXT(a_full_block_loads, absorb_acc && (r_fill == 6'd63), (r_state == ST_LOAD) && (r_fill == 6'd0), "full block did not start a compression")
    `SHS_ASSERT_NEXT(a_rounds_to_fold, (r_state == ST_ROUND) && (r_cnt == 6'd63), (r_state == ST_FIN) && (r_cnt == 6'd0), "round loop did not end in fold-back")
    `SHS_ASSERT_NEXT(a_digest_resets_chain, chn_clear, (r_chn_vld == 8'd0) && (r_state == ST_IDLE) && (r_len == 64'd0), "chaining state not back to initial after digest")

endmodule

@@ design/shs_compress.sv @@
// sha-256 compression datapath: 16-word schedule window and working variables
// depends on shs_pkg
`timescale 1ns / 1ps

module shs_compress (
    input  logic              i_clk,
    input  shs_pkg::t_cmp_ctrl i_ctrl,
    input  shs_pkg::t_word    i_word,
    input  shs_pkg::t_word    i_var,
    output shs_pkg::t_vars    o_vars
);
    import shs_pkg::*;

    t_sched r_w;
    t_sched n_w;
    t_vars  r_v;
    t_vars  n_v;
    t_word  w_new;
    t_word  ch;
    t_word  maj;
    t_word  t1;
    t_word  t2;

    always_comb begin
        // r_w[k] holds schedule word t+k during round t
        w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_sigma1(r_v[4]) + ch + K_TABLE[i_ctrl.rnd_idx] + r_w[0];
        t2    = big_sigma0(r_v[0]) + maj;

        n_w = r_w;
        if (i_ctrl.load_w) begin
            n_w = {i_word, r_w[15:1]};
        end else if (i_ctrl.round) begin
            n_w = {w_new, r_w[15:1]};
        end

        n_v = r_v;
        if (i_ctrl.load_v) begin
            n_v = {i_var, r_v[7:1]};
        end else if (i_ctrl.round) begin
            n_v[7] = r_v[6];
            n_v[6] = r_v[5];
            n_v[5] = r_v[4];
            n_v[4] = r_v[3] + t1;
            n_v[3] = r_v[2];
            n_v[2] = r_v[1];
            n_v[1] = r_v[0];
            n_v[0] = t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_v <= n_v;
    end

    assign o_vars = r_v;

endmodule
